// ----- rtl/lidar_body_box_mask_macros.svh -----
// Assertion macros for the lidar body box mask.
// Used by the top level; expects clk and rst in scope.
`ifndef LIDAR_BODY_BOX_MASK_MACROS_SVH
`define LIDAR_BODY_BOX_MASK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LBBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LBBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lbbm_pkg.sv -----
// Shared types, constants and trig table functions for the lidar body box mask.
// No dependencies; every file but the assertion macros header uses it.
package lbbm_pkg;

  localparam int SAMPLES_DEFAULT = 720;
  localparam int BEAM_W   = 10;
  localparam int RANGE_W  = 16;
  localparam int INTEN_W  = 16;
  localparam int TRIG_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [RANGE_W-1:0] NO_RETURN      = 16'hFFFF;
  localparam logic [RANGE_W-1:0] MASK_MARGIN_MM = 16'd1000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_FRONT  = 2'd0,
    REG_BOX_BACK   = 2'd1,
    REG_HALF_WIDTH = 2'd2,
    REG_RANGE_MAX  = 2'd3
  } cfg_reg_e;

  // Current box limits and range settings.
  typedef struct packed {
    logic signed [13:0] box_front;
    logic signed [13:0] box_back;
    logic [12:0]        box_half_width;
    logic [15:0]        range_max_mm;
  } cfg_t;

  // Per-stage load enables of the datapath.
  typedef struct packed {
    logic load1;
    logic load2;
    logic load3;
  } pipe_ctl_t;

  // Range given to a masked sample: range_max_mm + 1000, saturated.
  function automatic logic [RANGE_W-1:0] masked_range(input logic [RANGE_W-1:0] limit_mm);
    logic [RANGE_W:0] sum;
    sum = {1'b0, limit_mm} + {1'b0, MASK_MARGIN_MM};
    return sum[RANGE_W] ? NO_RETURN : sum[RANGE_W-1:0];
  endfunction

  // Q15 magnitude of sin(g * pi/2 / 2^30); table build only.
  function automatic logic [TRIG_W-1:0] quarter_sin(input logic [63:0] g);
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] r;
    theta = (g * HALF_PI_Q30) >> 30;
    t2    = (theta * theta) >> 30;
    term  = ONE_Q30 - (((t2 * ONE_Q30) >> 30) / 64'd110);
    term  = ONE_Q30 - (((t2 * term) >> 30) / 64'd72);
    term  = ONE_Q30 - (((t2 * term) >> 30) / 64'd42);
    term  = ONE_Q30 - (((t2 * term) >> 30) / 64'd20);
    term  = ONE_Q30 - (((t2 * term) >> 30) / 64'd6);
    s = (theta * term) >> 30;
    r = (s + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[TRIG_W-1:0];
  endfunction

  // Signed Q15 sine of a 32-bit fraction of a turn.
  function automatic logic [TRIG_W-1:0] phase_sin(input logic [31:0] phase);
    logic [63:0]       f;
    logic [63:0]       g;
    logic [TRIG_W-1:0] m;
    f = {34'd0, phase[29:0]};
    g = phase[30] ? (ONE_Q30 - f) : f;
    m = quarter_sin(g);
    return phase[31] ? (~m + 16'd1) : m;
  endfunction

  // Table entry: sine in the upper half, cosine in the lower half.
  function automatic logic [2*TRIG_W-1:0] trig_entry(input logic [31:0] phase);
    return {phase_sin(phase), phase_sin(phase + 32'h4000_0000)};
  endfunction

endpackage

// ----- rtl/lbbm_if.sv -----
// Valid/ready channel interfaces for lidar samples and masked results.
// Depends on lbbm_pkg for field widths.
interface lbbm_sample_if;
  logic                         valid;
  logic                         ready;
  logic [lbbm_pkg::BEAM_W-1:0]  beam_index;
  logic [lbbm_pkg::RANGE_W-1:0] range_in;
  logic [lbbm_pkg::INTEN_W-1:0] intensity_in;

  modport source (output valid, beam_index, range_in, intensity_in, input ready);
  modport sink (input valid, beam_index, range_in, intensity_in, output ready);
endinterface

interface lbbm_result_if;
  logic                         valid;
  logic                         ready;
  logic [lbbm_pkg::RANGE_W-1:0] range_out;
  logic [lbbm_pkg::INTEN_W-1:0] intensity_out;
  logic                         was_masked;

  modport source (output valid, range_out, intensity_out, was_masked, input ready);
  modport sink (input valid, range_out, intensity_out, was_masked, output ready);
endinterface

// ----- rtl/lbbm_cfg_regs.sv -----
// Configuration register file for the body box limits and maximum range.
// Depends on lbbm_pkg for the register index codes and cfg_t.
module lbbm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lbbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lbbm_pkg::cfg_t                  cfg
);
  import lbbm_pkg::*;

  // Write one register per enabled cycle; reset loads the default box.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_front      <= 14'sd90;
      cfg.box_back       <= -14'sd550;
      cfg.box_half_width <= 13'd190;
      cfg.range_max_mm   <= 16'd12000;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_BOX_FRONT:  cfg.box_front      <= $signed(cfg_wdata[13:0]);
        REG_BOX_BACK:   cfg.box_back       <= $signed(cfg_wdata[13:0]);
        REG_HALF_WIDTH: cfg.box_half_width <= cfg_wdata[12:0];
        REG_RANGE_MAX:  cfg.range_max_mm   <= cfg_wdata[15:0];
      endcase
    end
  end

endmodule

// ----- rtl/lbbm_trig_rom.sv -----
// Sine/cosine table indexed by beam index, with a registered read port.
// Depends on lbbm_pkg for the table build functions.
module lbbm_trig_rom #(
  parameter int SAMPLES = lbbm_pkg::SAMPLES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              load,
  input  logic [lbbm_pkg::BEAM_W-1:0]       beam_index,
  output logic signed [lbbm_pkg::TRIG_W-1:0] sin_q15,
  output logic signed [lbbm_pkg::TRIG_W-1:0] cos_q15,
  output logic                              beam_ok
);
  import lbbm_pkg::*;

  // Indexes past the reach of the beam field are never read.
  localparam int BeamSpan = 1 << BEAM_W;
  localparam int RomDepth = (SAMPLES < BeamSpan) ? SAMPLES : BeamSpan;
  localparam int AddrW    = $clog2(RomDepth);

  logic [2*TRIG_W-1:0] rom [RomDepth];
  logic                in_range;
  logic [AddrW-1:0]    addr;

  // Each entry holds the Q15 sine and cosine of index * 2pi / SAMPLES.
  for (genvar i = 0; i < RomDepth; i++) begin : g_rom
    localparam logic [31:0] Phase = 32'((64'(i) << 32) / SAMPLES);
    assign rom[i] = trig_entry(Phase);
  end

  // Out-of-scan beams read entry zero and are flagged.
  assign in_range = {{(32-BEAM_W){1'b0}}, beam_index} < 32'(SAMPLES);
  assign addr     = in_range ? beam_index[AddrW-1:0] : '0;

  // Registered read.
  always_ff @(posedge clk) begin
    if (load) begin
      sin_q15 <= $signed(rom[addr][2*TRIG_W-1:TRIG_W]);
      cos_q15 <= $signed(rom[addr][TRIG_W-1:0]);
      beam_ok <= in_range;
    end
  end

endmodule

// ----- rtl/lbbm_box_test.sv -----
// Datapath: point projection, body box compare and result register.
// Depends on lbbm_pkg for cfg_t, pipe_ctl_t and masked_range.
module lbbm_box_test (
  input  logic                              clk,
  input  lbbm_pkg::pipe_ctl_t               ctl,
  input  lbbm_pkg::cfg_t                    cfg,
  input  logic [lbbm_pkg::RANGE_W-1:0]      range_in,
  input  logic [lbbm_pkg::INTEN_W-1:0]      intensity_in,
  input  logic signed [lbbm_pkg::TRIG_W-1:0] sin_q15,
  input  logic signed [lbbm_pkg::TRIG_W-1:0] cos_q15,
  input  logic                              beam_ok,
  output logic [lbbm_pkg::RANGE_W-1:0]      range_out,
  output logic [lbbm_pkg::INTEN_W-1:0]      intensity_out,
  output logic                              was_masked
);
  import lbbm_pkg::*;

  localparam int ProdW = RANGE_W + TRIG_W + 1;
  localparam int CmpW  = 34;

  logic [RANGE_W-1:0]     range1;
  logic [INTEN_W-1:0]     inten1;
  logic signed [ProdW-1:0] x_prod;
  logic signed [ProdW-1:0] y_prod;
  logic [RANGE_W-1:0]     range2;
  logic [INTEN_W-1:0]     inten2;
  logic                   elig2;
  logic signed [CmpW-1:0] x_w;
  logic signed [CmpW-1:0] y_w;
  logic signed [CmpW-1:0] side_q;
  logic signed [CmpW-1:0] front_q;
  logic signed [CmpW-1:0] back_q;
  logic                   in_box;

  // Stage 1: hold the sample next to the table read.
  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      range1 <= range_in;
      inten1 <= intensity_in;
    end
  end

  // Stage 2: exact Q15 products x = range*sin, y = range*cos.
  always_ff @(posedge clk) begin
    if (ctl.load2) begin
      x_prod <= $signed({1'b0, range1}) * sin_q15;
      y_prod <= $signed({1'b0, range1}) * cos_q15;
      range2 <= range1;
      inten2 <= inten1;
      elig2  <= beam_ok && (range1 != NO_RETURN);
    end
  end

  // Limits scaled to Q15 millimetres.
  assign x_w     = CmpW'(x_prod);
  assign y_w     = CmpW'(y_prod);
  assign side_q  = $signed({6'd0, cfg.box_half_width, 15'd0});
  assign front_q = CmpW'($signed({cfg.box_front, 15'd0}));
  assign back_q  = CmpW'($signed({cfg.box_back, 15'd0}));
  assign in_box  = (x_w > -side_q) && (x_w < side_q) && (y_w < front_q) && (y_w > back_q);

  // Stage 3: result register.
  always_ff @(posedge clk) begin
    if (ctl.load3) begin
      was_masked    <= elig2 && in_box;
      range_out     <= (elig2 && in_box) ? masked_range(cfg.range_max_mm) : range2;
      intensity_out <= inten2;
    end
  end

endmodule

// ----- rtl/lidar_body_box_mask.sv -----
// Lidar body box mask: an accepted item reaches result valid through the stages below.
// Throughput is one item per cycle while result.ready holds; the stages are the table read register,
// the multiplier register and the compare/result register.
// Each stage stalls only when the stage after it is full and not moving.
// Synchronous reset empties the pipeline and loads the default box limits.
module lidar_body_box_mask #(
  parameter int SAMPLES = lbbm_pkg::SAMPLES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  lbbm_sample_if.sink                     sample,
  lbbm_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [lbbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbbm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lbbm_pkg::*;

  cfg_t                      cfg;
  pipe_ctl_t                 ctl;
  logic                      s1_valid;
  logic                      s2_valid;
  logic                      s3_valid;
  logic                      en1;
  logic                      en2;
  logic                      en3;
  logic signed [TRIG_W-1:0]  sin_q15;
  logic signed [TRIG_W-1:0]  cos_q15;
  logic                      beam_ok;

  lbbm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // A stage moves when the next one is empty or moving too.
  assign en3 = !s3_valid || result.ready;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;

  assign sample.ready = en1;
  assign result.valid = s3_valid;

  assign ctl.load1 = sample.valid && en1;
  assign ctl.load2 = s1_valid && en2;
  assign ctl.load3 = s2_valid && en3;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= sample.valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  lbbm_trig_rom #(
    .SAMPLES (SAMPLES)
  ) u_rom (
    .clk        (clk),
    .load       (ctl.load1),
    .beam_index (sample.beam_index),
    .sin_q15    (sin_q15),
    .cos_q15    (cos_q15),
    .beam_ok    (beam_ok)
  );

  lbbm_box_test u_box (
    .clk           (clk),
    .ctl           (ctl),
    .cfg           (cfg),
    .range_in      (sample.range_in),
    .intensity_in  (sample.intensity_in),
    .sin_q15       (sin_q15),
    .cos_q15       (cos_q15),
    .beam_ok       (beam_ok),
    .range_out     (result.range_out),
    .intensity_out (result.intensity_out),
    .was_masked    (result.was_masked)
  );

  // Checks on the pipeline control and the masked result.
  `include "lidar_body_box_mask_macros.svh"

  `LBBM_ASSERT_NEXT(a_accept_fills_s1, sample.valid && sample.ready, s1_valid, "accepted item lost")
  `LBBM_ASSERT_NOW(a_ready_when_s1_free, !s1_valid, sample.ready, "input stalled with free stage")
  `LBBM_ASSERT_NOW(a_masked_value, result.valid && result.was_masked, result.range_out == masked_range(cfg.range_max_mm), "masked range wrong")

endmodule
